FILE: src/ngps_pkg.sv
// ----------------------------------------------------------------------------
// ngps_pkg
// Shared constants and types for the nearest grid point search block:
// field widths, stream packing, function codes and controller interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ngps_pkg;

  // Default geometry
  localparam int NUM_GRIDS_DEF = 4;
  localparam int GRID_SIDE_DEF = 26;

  // Field widths
  localparam int FUNC_W      = 1;
  localparam int GRID_SEL_W  = 2;
  localparam int POINT_SEL_W = 10;
  localparam int COORD_W     = 31;
  localparam int DIST_W      = 62;
  localparam int SUM_W       = 2 * COORD_W + 1;

  // Stream widths (payload padded to whole bytes)
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // Function codes carried in in_tuser
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the input item
    logic wr_en;       // store the latched point
    logic scan_start;  // reset scan counters and best match
    logic scan_en;     // issue one table read and advance
    logic load_out;    // move the best match into the output register
  } ngps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;    // latched item is a query
    logic scan_last;   // scan address is at the final entry
    logic pipe_empty;  // no read still in flight
    logic out_free;    // output register can take a result
  } ngps_sts_t;

endpackage

`default_nettype wire

FILE: src/ngps_ram.sv
// ----------------------------------------------------------------------------
// ngps_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ngps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/ngps_ctrl.sv
// ----------------------------------------------------------------------------
// ngps_ctrl
// Controller for the nearest grid point search: takes one item at a time,
// stores points, sequences the table scan and hands the result out.
// ----------------------------------------------------------------------------
`default_nettype none

module ngps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire ngps_pkg::ngps_sts_t sts,
  output ngps_pkg::ngps_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.capture    = in_tvalid && (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_query) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          cmd.wr_en = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last compare and a free output slot
        if (sts.pipe_empty && sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/ngps_dp.sv
// ----------------------------------------------------------------------------
// ngps_dp
// Datapath for the nearest grid point search: coordinate tables, scan
// address counters, distance pipeline, best-match tracking and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ngps_dp #(
  parameter int NUM_GRIDS = ngps_pkg::NUM_GRIDS_DEF,
  parameter int GRID_SIDE = ngps_pkg::GRID_SIDE_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire ngps_pkg::ngps_cmd_t                       cmd,
  output ngps_pkg::ngps_sts_t                            sts,
  input  wire logic        [ngps_pkg::FUNC_W-1:0]        in_func,
  input  wire logic        [ngps_pkg::GRID_SEL_W-1:0]    in_grid_sel,
  input  wire logic        [ngps_pkg::POINT_SEL_W-1:0]   in_point_sel,
  input  wire logic signed [ngps_pkg::COORD_W-1:0]       in_coord_lat,
  input  wire logic signed [ngps_pkg::COORD_W-1:0]       in_coord_lon,
  input  wire logic                                      out_tready,
  output logic                                           out_tvalid,
  output logic             [ngps_pkg::POINT_SEL_W-1:0]   out_nearest_point,
  output logic             [ngps_pkg::GRID_SEL_W-1:0]    out_nearest_grid,
  output logic             [ngps_pkg::DIST_W-1:0]        out_best_distance
);

  localparam int PTS   = GRID_SIDE * GRID_SIDE;
  localparam int DEPTH = NUM_GRIDS * PTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (PTS > 1) ? $clog2(PTS) : 1;
  localparam int GW    = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1;
  localparam int CW    = ngps_pkg::COORD_W;
  localparam int SW    = ngps_pkg::SUM_W;
  localparam int DW    = ngps_pkg::DIST_W;

  // Latched input item
  logic [ngps_pkg::FUNC_W-1:0]      func_r;
  logic [ngps_pkg::GRID_SEL_W-1:0]  w_grid_r;
  logic [ngps_pkg::POINT_SEL_W-1:0] w_point_r;
  logic signed [CW-1:0]             q_lat_r;
  logic signed [CW-1:0]             q_lon_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r    <= in_func;
      w_grid_r  <= in_grid_sel;
      w_point_r <= in_point_sel;
      q_lat_r   <= in_coord_lat;
      q_lon_r   <= in_coord_lon;
    end
  end

  // Write address; out-of-range writes are dropped
  logic          wr_ok;
  logic [AW-1:0] waddr;
  logic          we;

  assign wr_ok = (int'(w_grid_r) < NUM_GRIDS) && (int'(w_point_r) < PTS);
  assign waddr = AW'(int'(w_grid_r) * PTS + int'(w_point_r));
  assign we    = cmd.wr_en && wr_ok;

  // Scan counters: flat address plus grid and point tags
  logic [AW-1:0] addr_r;
  logic [GW-1:0] g_cnt_r;
  logic [PW-1:0] p_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      addr_r  <= '0;
      g_cnt_r <= '0;
      p_cnt_r <= '0;
    end else if (cmd.scan_en) begin
      addr_r <= addr_r + AW'(1);
      if (p_cnt_r == PW'(PTS - 1)) begin
        p_cnt_r <= '0;
        g_cnt_r <= g_cnt_r + GW'(1);
      end else begin
        p_cnt_r <= p_cnt_r + PW'(1);
      end
    end
  end

  // Coordinate tables
  logic [CW-1:0] rd_lat;
  logic [CW-1:0] rd_lon;

  ngps_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_lat_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_lat_r),
    .re    (cmd.scan_en),
    .raddr (addr_r),
    .rdata (rd_lat)
  );

  ngps_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_lon_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_lon_r),
    .re    (cmd.scan_en),
    .raddr (addr_r),
    .rdata (rd_lon)
  );

  // Stage 1: read data arrives, tags follow
  logic          v1_r;
  logic [GW-1:0] g1_r;
  logic [PW-1:0] p1_r;

  always_ff @(posedge clk) begin
    g1_r <= g_cnt_r;
    p1_r <= p_cnt_r;
  end

  // Stage 2: absolute coordinate differences
  logic signed [CW:0] d_lat;
  logic signed [CW:0] d_lon;
  logic [CW:0]        n_lat;
  logic [CW:0]        n_lon;
  logic               v2_r;
  logic [GW-1:0]      g2_r;
  logic [PW-1:0]      p2_r;
  logic [CW-1:0]      a_lat_r;
  logic [CW-1:0]      a_lon_r;

  assign d_lat = {q_lat_r[CW-1], q_lat_r} - {rd_lat[CW-1], rd_lat};
  assign d_lon = {q_lon_r[CW-1], q_lon_r} - {rd_lon[CW-1], rd_lon};
  assign n_lat = d_lat[CW] ? (~d_lat + (CW+1)'(1)) : d_lat;
  assign n_lon = d_lon[CW] ? (~d_lon + (CW+1)'(1)) : d_lon;

  always_ff @(posedge clk) begin
    a_lat_r <= n_lat[CW-1:0];
    a_lon_r <= n_lon[CW-1:0];
    g2_r    <= g1_r;
    p2_r    <= p1_r;
  end

  // Stage 3: squares
  logic            v3_r;
  logic [GW-1:0]   g3_r;
  logic [PW-1:0]   p3_r;
  logic [2*CW-1:0] sq_lat_r;
  logic [2*CW-1:0] sq_lon_r;

  always_ff @(posedge clk) begin
    sq_lat_r <= a_lat_r * a_lat_r;
    sq_lon_r <= a_lon_r * a_lon_r;
    g3_r     <= g2_r;
    p3_r     <= p2_r;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 4: exact sum and compare; strict less-than keeps the earliest point
  logic [SW-1:0] sum;
  logic          found_r;
  logic [SW-1:0] best_r;
  logic [GW-1:0] best_g_r;
  logic [PW-1:0] best_p_r;

  assign sum = {1'b0, sq_lat_r} + {1'b0, sq_lon_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.scan_start) begin
      found_r <= 1'b0;
    end else if (v3_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && (!found_r || (sum < best_r))) begin
      best_r   <= sum;
      best_g_r <= g3_r;
      best_p_r <= p3_r;
    end
  end

  // Output register, distance saturated to the field
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_nearest_point <= ngps_pkg::POINT_SEL_W'(best_p_r);
      out_nearest_grid  <= ngps_pkg::GRID_SEL_W'(best_g_r);
      out_best_distance <= best_r[SW-1] ? {DW{1'b1}} : best_r[DW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;

  // Status
  assign sts.is_query   = (func_r == ngps_pkg::FUNC_QUERY);
  assign sts.scan_last  = (addr_r == AW'(DEPTH - 1));
  assign sts.pipe_empty = !v1_r && !v2_r && !v3_r;
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

`default_nettype wire

FILE: src/nearest_grid_point_search.sv
// ----------------------------------------------------------------------------
// nearest_grid_point_search
// Nearest stored point by squared Euclidean distance over several grids.
// ----------------------------------------------------------------------------
// A write item (in_tuser = 0) stores one latitude/longitude pair at a grid and
// point index; writes outside the grid geometry are dropped silently. A query
// item (in_tuser = 1) scans every stored point, grid by grid, reading one entry
// per cycle from the coordinate tables through the single read port of each
// table, and takes no new item until its result is in the output register.
// One item is worked on at a time, but a finished result waits in the
// output register while the next item is taken. Ties go to the earliest
// point scanned; the distance saturates at 2^62-1. The tables are not cleared
// at reset: every entry must be written before a query reads it.
`default_nettype none

module nearest_grid_point_search #(
  parameter int NUM_GRIDS = ngps_pkg::NUM_GRIDS_DEF,
  parameter int GRID_SIDE = ngps_pkg::GRID_SIDE_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input channel
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [ngps_pkg::FUNC_W-1:0]          in_tuser,  // func
  // grid_sel[1:0], point_sel[11:2], coord_lat[42:12], coord_lon[73:43]
  input  wire logic [ngps_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Result channel
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // nearest_point[9:0], nearest_grid[11:10], best_distance[73:12]
  output logic      [ngps_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  ngps_pkg::ngps_cmd_t cmd;
  ngps_pkg::ngps_sts_t sts;

  logic [ngps_pkg::POINT_SEL_W-1:0] nearest_point;
  logic [ngps_pkg::GRID_SEL_W-1:0]  nearest_grid;
  logic [ngps_pkg::DIST_W-1:0]      best_distance;

  ngps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ngps_dp #(
    .NUM_GRIDS (NUM_GRIDS),
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_tuser),
    .in_grid_sel       (in_tdata[1:0]),
    .in_point_sel      (in_tdata[11:2]),
    .in_coord_lat      (in_tdata[42:12]),
    .in_coord_lon      (in_tdata[73:43]),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_nearest_point (nearest_point),
    .out_nearest_grid  (nearest_grid),
    .out_best_distance (best_distance)
  );

  // Result packing, padded to whole bytes
  assign out_tdata = {6'd0, best_distance, nearest_grid, nearest_point};

endmodule

`default_nettype wire

FILE: src/ngps_checker.sv
// ----------------------------------------------------------------------------
// ngps_checker
// Port-level checks for the nearest grid point search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ngps_checker #(
  parameter int NUM_GRIDS = ngps_pkg::NUM_GRIDS_DEF,
  parameter int GRID_SIDE = ngps_pkg::GRID_SIDE_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic [ngps_pkg::FUNC_W-1:0]        in_tuser,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [ngps_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int PTS = GRID_SIDE * GRID_SIDE;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Reported location lies inside the grid geometry
  a_loc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[11:10]) < NUM_GRIDS) && (int'(out_tdata[9:0]) < PTS))
    else $error("nearest point outside grid geometry");

  // A stored point never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == ngps_pkg::FUNC_WRITE) |=> !$rose(out_tvalid))
    else $error("result raised after a write transfer");

  // The scan keeps the input closed after a query is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == ngps_pkg::FUNC_QUERY) |=> !in_tready)
    else $error("input ready straight after a query transfer");

endmodule

bind nearest_grid_point_search ngps_checker #(
  .NUM_GRIDS (NUM_GRIDS),
  .GRID_SIDE (GRID_SIDE)
) u_checker (.*);

`default_nettype wire

FILE: sim/tb_nearest_grid_point_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_grid_point_search
// Self-checking bench for the nearest grid point search block. Every table
// entry is written before the first query. The bench then runs directed
// queries (saturated distance, ties, extreme coordinates, dropped writes),
// refills the tables at random and ends with a random mix of writes and
// queries. A local model of the tables predicts each query result, and the
// results are checked in order against it while both stream sides throttle.
// ----------------------------------------------------------------------------

module tb_nearest_grid_point_search;

  import ngps_pkg::*;

  // Geometry and run lengths
  localparam int NUM_GRIDS      = NUM_GRIDS_DEF;
  localparam int GRID_SIDE      = GRID_SIDE_DEF;
  localparam int PTS_PER_GRID   = GRID_SIDE * GRID_SIDE;
  localparam int STORE_DEPTH    = NUM_GRIDS * PTS_PER_GRID;
  localparam int SCAN_CYCLES    = STORE_DEPTH + 8;
  localparam int HOLD_CYCLES    = 3 * SCAN_CYCLES;
  localparam int HOLD_AT_RESULT = 14;
  localparam int IDLE_LIMIT     = 4 * (HOLD_CYCLES + SCAN_CYCLES);
  localparam int DRAIN_CYCLES   = SCAN_CYCLES + 16;
  localparam int RANDOM_ITEMS   = 220;

  // Coordinate landmarks in 2^-22 degree units
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int                        DEG180    = 754974720;
  localparam logic [63:0]               DIST_MAX  = {2'b00, {DIST_W{1'b1}}};

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic [GRID_SEL_W-1:0]     grid;
    logic [POINT_SEL_W-1:0]    point;
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
  } grid_item_t;

  // Packed in the same order as out_tdata, lowest field last
  typedef struct packed {
    logic [DIST_W-1:0]      distance;
    logic [GRID_SEL_W-1:0]  grid;
    logic [POINT_SEL_W-1:0] point;
  } nearest_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

  // DUT connections
  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [FUNC_W-1:0]      in_tuser   = FUNC_WRITE;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Bench state
  grid_item_t                pending_items[$];
  nearest_t                  nearest_q[$];
  logic signed [COORD_W-1:0] point_lat [STORE_DEPTH];
  logic signed [COORD_W-1:0] point_lon [STORE_DEPTH];
  logic signed [COORD_W-1:0] plan_lat  [STORE_DEPTH];
  logic signed [COORD_W-1:0] plan_lon  [STORE_DEPTH];
  int  items_pushed   = 0;
  int  items_accepted = 0;
  int  results_seen   = 0;
  int  mismatch_count = 0;
  int  n_writes       = 0;
  int  n_dropped      = 0;
  int  n_queries      = 0;
  bit  item_taken     = 1'b0;

  nearest_grid_point_search #(
    .NUM_GRIDS (NUM_GRIDS),
    .GRID_SIDE (GRID_SIDE)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Linear scan over the local tables; first point scanned wins a tie
  function automatic nearest_t find_nearest(input logic signed [COORD_W-1:0] qlat,
                                            input logic signed [COORD_W-1:0] qlon);
    nearest_t    best;
    logic [63:0] best_sum;
    logic [63:0] sum;
    longint      dlat;
    longint      dlon;
    int          idx;
    best     = '0;
    best_sum = '1;
    for (int g = 0; g < NUM_GRIDS; g++) begin
      for (int p = 0; p < PTS_PER_GRID; p++) begin
        idx  = g * PTS_PER_GRID + p;
        dlat = longint'(qlat) - longint'(point_lat[idx]);
        dlon = longint'(qlon) - longint'(point_lon[idx]);
        if (dlat < 0) dlat = -dlat;
        if (dlon < 0) dlon = -dlon;
        sum = dlat * dlat;
        sum = sum + dlon * dlon;
        if (idx == 0 || sum < best_sum) begin
          best_sum   = sum;
          best.grid  = GRID_SEL_W'(g);
          best.point = POINT_SEL_W'(p);
        end
      end
    end
    best.distance = (best_sum > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : best_sum[DIST_W-1:0];
    return best;
  endfunction

  // Mostly inside +-180 degrees, some full-width values, some landmarks
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 70) begin
      v = int'($urandom_range(2 * DEG180, 0)) - DEG180;
      return v[COORD_W-1:0];
    end
    if (pick < 85) begin
      v = $urandom;
      return v[COORD_W-1:0];
    end
    case ($urandom_range(4))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return COORD_W'(DEG180);
      3:       return COORD_W'(-DEG180);
      default: return '0;
    endcase
  endfunction

  // Queue one item and track what the tables will hold once it is taken
  task automatic push_item(input logic [FUNC_W-1:0] func,
                           input int grid, input int point,
                           input logic signed [COORD_W-1:0] lat,
                           input logic signed [COORD_W-1:0] lon);
    grid_item_t it;
    it.func  = func;
    it.grid  = GRID_SEL_W'(grid);
    it.point = POINT_SEL_W'(point);
    it.lat   = lat;
    it.lon   = lon;
    if (func == FUNC_WRITE && point < PTS_PER_GRID) begin
      plan_lat[grid * PTS_PER_GRID + point] = lat;
      plan_lon[grid * PTS_PER_GRID + point] = lon;
    end
    pending_items.push_back(it);
    items_pushed++;
  endtask

  // Input driver: bursts of items separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    grid_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || item_taken) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_tuser  <= it.func;
        in_tdata  <= IN_TDATA_W'({it.lon, it.lat, it.point, it.grid});
        in_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(3) == 0) ? $urandom_range(300, 50)
                                                : $urandom_range(12, 1);
          gap_left   = ($urandom_range(3) == 0) ? $urandom_range(40, 5)
                                                : $urandom_range(3, 0);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: changing stall pattern plus one long hold-off
  rx_mode_t rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       stall_left = 0;
  bit       hold_done  = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
      // keep the result register full so the block backs up its input
      hold_done  = 1'b1;
      stall_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(2));
        mode_left = $urandom_range(400, 16);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_HALF:   out_tready <= ($urandom_range(1) == 1);
        default:   out_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    logic [POINT_SEL_W-1:0]    wr_point;
    logic [GRID_SEL_W-1:0]     wr_grid;
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
    nearest_t                  got;
    nearest_t                  want;
    if (rst_n && in_tvalid && in_tready) begin
      wr_grid  = in_tdata[1:0];
      wr_point = in_tdata[11:2];
      lat      = in_tdata[42:12];
      lon      = in_tdata[73:43];
      if (in_tuser == FUNC_QUERY) begin
        nearest_q.push_back(find_nearest(lat, lon));
        n_queries++;
      end else if (wr_grid < NUM_GRIDS && wr_point < PTS_PER_GRID) begin
        point_lat[wr_grid * PTS_PER_GRID + wr_point] = lat;
        point_lon[wr_grid * PTS_PER_GRID + wr_point] = lon;
        n_writes++;
      end else begin
        n_dropped++;
      end
      items_accepted++;
      item_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[DIST_W+GRID_SEL_W+POINT_SEL_W-1:0];
      results_seen++;
      if (nearest_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: point %0d grid %0d distance %0d",
                   got.point, got.grid, got.distance);
      end else begin
        want = nearest_q.pop_front();
        if (got.point !== want.point || got.grid !== want.grid ||
            got.distance !== want.distance) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected point %0d grid %0d distance %0d, %s %0d %0d %0d",
                     want.point, want.grid, want.distance, "got point/grid/distance",
                     got.point, got.grid, got.distance);
        end
      end
    end
  end

  // Watchdog on transfer activity
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("tb_nearest_grid_point_search failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic signed [COORD_W-1:0] tie_lat;
    logic signed [COORD_W-1:0] tie_lon;
    int counted;
    int pick;
    int idx;
    int v_lat;
    int v_lon;

    // Every entry at the far negative corner before anything reads it
    for (int g = 0; g < NUM_GRIDS; g++)
      for (int p = 0; p < PTS_PER_GRID; p++)
        push_item(FUNC_WRITE, g, p, COORD_MIN, COORD_MIN);

    // All points equal: saturated distance, zero distance, ties to the first
    push_item(FUNC_QUERY, 3, 1023, COORD_MAX, COORD_MAX);
    push_item(FUNC_QUERY, 0, 0, COORD_MIN, COORD_MIN);
    push_item(FUNC_QUERY, 2, 513, '0, '0);
    // Last entry of the last grid moved to the positive corner
    push_item(FUNC_WRITE, NUM_GRIDS - 1, PTS_PER_GRID - 1, COORD_MAX, COORD_MAX);
    push_item(FUNC_QUERY, 1, 7, COORD_MAX, COORD_MAX);
    push_item(FUNC_QUERY, 0, 0, '0, '0);
    // Writes past the end of a grid are dropped
    push_item(FUNC_WRITE, 0, 1023, '0, '0);
    push_item(FUNC_WRITE, 3, PTS_PER_GRID, '0, '0);
    push_item(FUNC_QUERY, 0, 0, '0, '0);

    // Random refill of the whole table
    for (int g = 0; g < NUM_GRIDS; g++)
      for (int p = 0; p < PTS_PER_GRID; p++)
        push_item(FUNC_WRITE, g, p, rand_coord(), rand_coord());

    // Two points at one coordinate: the earlier grid wins
    tie_lat = 31'sd123456;
    tie_lon = -31'sd654321;
    push_item(FUNC_WRITE, 2, 10, tie_lat, tie_lon);
    push_item(FUNC_WRITE, 1, 5, tie_lat, tie_lon);
    push_item(FUNC_QUERY, 0, 0, tie_lat, tie_lon);
    // +-180 degree corners
    push_item(FUNC_WRITE, 0, 0, COORD_W'(DEG180), COORD_W'(-DEG180));
    push_item(FUNC_QUERY, 3, 1023, COORD_W'(DEG180), COORD_W'(-DEG180));
    push_item(FUNC_QUERY, 0, 0, COORD_W'(-DEG180), COORD_W'(DEG180));
    push_item(FUNC_QUERY, 1, 340, COORD_MIN, COORD_MAX);
    push_item(FUNC_WRITE, 3, 1023, COORD_MAX, COORD_MIN);
    push_item(FUNC_QUERY, 2, 682, COORD_MAX, COORD_MIN);

    // Random mix; dropped writes do not count towards the total
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        push_item(FUNC_WRITE, $urandom_range(NUM_GRIDS - 1),
                  $urandom_range(PTS_PER_GRID - 1), rand_coord(), rand_coord());
        counted++;
      end else if (pick < 58) begin
        push_item(FUNC_WRITE, $urandom_range(3), $urandom_range(1023, PTS_PER_GRID),
                  rand_coord(), rand_coord());
      end else begin
        idx = $urandom_range(STORE_DEPTH - 1);
        if (pick < 80) begin
          // close to a stored point
          v_lat = int'(plan_lat[idx]) + int'($urandom_range(2000)) - 1000;
          v_lon = int'(plan_lon[idx]) + int'($urandom_range(2000)) - 1000;
          push_item(FUNC_QUERY, $urandom_range(3), $urandom_range(1023),
                    v_lat[COORD_W-1:0], v_lon[COORD_W-1:0]);
        end else if (pick < 90) begin
          push_item(FUNC_QUERY, $urandom_range(3), $urandom_range(1023),
                    plan_lat[idx], plan_lon[idx]);
        end else begin
          push_item(FUNC_QUERY, $urandom_range(3), $urandom_range(1023),
                    rand_coord(), rand_coord());
        end
        counted++;
      end
    end

    // Drain: all items taken, all results back, then allow one more scan
    @(posedge rst_n);
    while (items_accepted != items_pushed || nearest_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d point writes, %0d dropped writes and %0d nearest-point queries",
             n_writes, n_dropped, n_queries);
    $display("Checked %0d results with %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("tb_nearest_grid_point_search passed");
    else
      $display("tb_nearest_grid_point_search failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/ngps_pkg.sv
src/ngps_ram.sv
src/ngps_ctrl.sv
src/ngps_dp.sv
src/nearest_grid_point_search.sv
src/ngps_checker.sv
sim/tb_nearest_grid_point_search.sv
